// ----- sv/spq_pkg.sv -----
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

  // Default number of cells in the chain.
  localparam int DEPTH_DEF = 16;

  localparam int VAL_W = 32;
  localparam int CMD_W = 2;
  localparam int STAT_W = 2;
  localparam int POS_W = 4;
  localparam int LEN_W = 5;

  // Command codes. Code 3 has no meaning and is ignored.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e_t;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e_t;

  // Input word.
  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        position;
    logic [LEN_W-1:0]        length;
    logic signed [VAL_W-1:0] head_value;
    logic                    head_valid;
  } out_word_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
  } spq_op_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    valid;
    logic                    ins;
    logic                    eq;
  } spq_link_t;

endpackage

// ----- sv/spq_cell.sv -----
// One storage cell of the sorted chain, with its compare and shift logic.
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  spq_op_t                 op,
  input  spq_link_t               prev_link,
  input  spq_link_t               next_link,
  output spq_link_t               link,
  output logic                    first_eq,
  output logic signed [VAL_W-1:0] value_nxt
);

  logic signed [VAL_W-1:0] value_r;
  logic                    valid_r;
  logic                    valid_nxt;
  logic                    lt;
  logic                    le;

  // Compare the stored value against the broadcast operand.
  assign lt = valid_r && (value_r < op.value);
  assign le = !valid_r || (value_r <= op.value);

  // A cell takes an insert when it is empty or holds a smaller value.
  assign link.value = value_r;
  assign link.valid = valid_r;
  assign link.ins   = !valid_r || lt;
  assign link.eq    = valid_r && (value_r == op.value);

  // Equal entries sit together, so the first one has no equal cell above it.
  assign first_eq = link.eq && !prev_link.eq;

  // Shift down on insert, shift up from the removed slot on remove.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (op.ins) begin
      if (prev_link.ins) begin
        value_nxt = prev_link.value;
        valid_nxt = prev_link.valid;
      end else if (link.ins) begin
        value_nxt = op.value;
        valid_nxt = 1'b1;
      end
    end else if (op.rem && le) begin
      value_nxt = next_link.value;
      valid_nxt = next_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue: a chain of compare-and-shift cells under one controller.
//
// The queue holds up to DEPTH signed values in descending order in a row of
// cells; every cell compares its value with the command word at once, so each
// command updates the whole chain together. A word is accepted at
// any rising edge with start high and busy low, and busy is low whenever the
// block is out of reset, so one word a cycle may be issued. The command word
// is first registered so that it can be fanned out to all cells, and the
// result word is registered in turn and appears on out_word with out_strobe
// high, for one cycle only; results are never held back, so the
// receiver must take them when they come. Inserts keep equal values in order
// of arrival, an insert into a full queue is dropped with status full, and
// remove or find of an absent value reports not found.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Command register that fans the word out to the chain.
  logic                    op_vld_r;
  logic [CMD_W-1:0]        op_cmd_r;
  logic signed [VAL_W-1:0] op_val_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_strobe_r;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  spq_op_t                 op;
  spq_link_t               links [DEPTH];
  logic                    first_eq [DEPTH];
  logic signed [VAL_W-1:0] cell_nxt [DEPTH];
  spq_link_t               edge_prev;
  spq_link_t               edge_next;

  logic             found;
  logic [POS_W-1:0] pos;
  logic             full;

  assign busy = ~rst_n;

  // Register the accepted command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else begin
      op_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_cmd_r <= in_word.command;
    op_val_r <= in_word.value;
  end

  // Boundary links: nothing above the head, an empty cell past the tail.
  assign edge_prev = '{value: '0, valid: 1'b1, ins: 1'b0, eq: 1'b0};
  assign edge_next = '{value: '0, valid: 1'b0, ins: 1'b1, eq: 1'b0};

  // The chain of cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .prev_link ((g == 0) ? edge_prev : links[(g == 0) ? 0 : g - 1]),
      .next_link ((g == DEPTH - 1) ? edge_next : links[(g == DEPTH - 1) ? g : g + 1]),
      .link      (links[g]),
      .first_eq  (first_eq[g]),
      .value_nxt (cell_nxt[g])
    );
  end

  // Collect the match and encode its position; at most one cell matches first.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | first_eq[i];
      if (first_eq[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  assign full = (count_r == CNT_W'(DEPTH));

  // Decide the operation and build the result word.
  always_comb begin
    op.ins       = 1'b0;
    op.rem       = 1'b0;
    op.value     = op_val_r;
    count_nxt    = count_r;
    out_word_nxt.status   = ST_DONE;
    out_word_nxt.position = '0;
    if (op_vld_r) begin
      unique case (op_cmd_r)
        CMD_INSERT: begin
          if (full) begin
            out_word_nxt.status = ST_FULL;
          end else begin
            op.ins    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (found) begin
            op.rem    = 1'b1;
            count_nxt = count_r - 1'b1;
            out_word_nxt.position = pos;
          end else begin
            out_word_nxt.status = ST_NOT_FOUND;
          end
        end
        CMD_FIND: begin
          if (found) begin
            out_word_nxt.position = pos;
          end else begin
            out_word_nxt.status = ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
    out_word_nxt.length     = LEN_W'(count_nxt);
    out_word_nxt.head_valid = (count_nxt != '0);
    out_word_nxt.head_value = (count_nxt != '0) ? cell_nxt[0] : '0;
  end

  // Entry count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= op_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ----- sv/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker
  import spq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input out_word_t out_word,
  input logic      out_strobe
);

  // Every accepted word yields a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("accepted word produced no result");

  // No result appears without an earlier accepted word.
  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  // An empty queue reports a zero length and a zero head.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.head_valid) |->
      (out_word.length == '0 && out_word.head_value == '0))
    else $error("empty queue reports a head or a length");

  // A dropped insert leaves position at zero and the queue not empty.
  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == ST_FULL) |->
      (out_word.position == '0 && out_word.head_valid))
    else $error("full status with bad position or empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_word   (out_word),
  .out_strobe (out_strobe)
);
